FILE: src/msgc_pkg.sv
// shared constants and types for the multi-stop gradient color block
// no dependencies; imported by every module of the block
package msgc_pkg;

   localparam int MAX_STOPS   = 6;
   localparam int TABLE_DEPTH = 4096;
   localparam int CHAN_W      = 16;
   localparam int ONE_VALUE   = 16384;
   localparam int NCHAN       = 3;
   localparam int NSEG        = MAX_STOPS - 1;

   localparam int IDX_W   = 12;
   localparam int LEN_W   = 13;
   localparam int CNT_W   = 3;
   localparam int STOP_W  = NCHAN * CHAN_W;
   localparam int SEG_W   = 3;
   localparam int OUT_W   = 15;
   localparam int DEN_W   = 12;
   localparam int P_W     = 15;
   localparam int MUL_W   = 14;
   localparam int PA_W    = 28;
   localparam int PB_W    = 30;
   localparam int T_W     = 30;
   localparam int NUM_W   = 28;
   localparam int DIV_W   = DEN_W + 1;
   localparam int QUO_W   = 15;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int STOP_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_COUNT   = 3'd0,
      CSR_TABLE_LENGTH = 3'd1,
      CSR_STOP_0       = 3'd2,
      CSR_STOP_1       = 3'd3,
      CSR_STOP_2       = 3'd4,
      CSR_STOP_3       = 3'd5,
      CSR_STOP_4       = 3'd6,
      CSR_STOP_5       = 3'd7
   } csr_index_type;

   typedef logic [STOP_W-1:0] stop_type;

   // one item on its way through the divider
   typedef struct packed {
      logic                        err;
      logic                        zero;
      logic [DIV_W-1:0]            den;
      logic [NCHAN-1:0][NUM_W-1:0] rem;
      logic [NCHAN-1:0][QUO_W-1:0] quo;
   } div_stage_type;

endpackage

FILE: src/msgc_front.sv
// front stages: segment select, interpolation products and rounding numerators
// depends on msgc_pkg; feeds msgc_div
module msgc_front
   import msgc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pipe_en,
   input  logic                 in_valid,
   input  logic [IDX_W-1:0]     in_index,
   input  logic [CNT_W-1:0]     stop_count,
   input  logic [LEN_W-1:0]     table_length,
   input  stop_type             stops [MAX_STOPS],
   output logic                 out_valid,
   output div_stage_type        out_item
);

   function automatic logic signed [CHAN_W-1:0] chan_of(input stop_type s, input int c);
      return $signed(s[STOP_W-1-c*CHAN_W -: CHAN_W]);
   endfunction

   // stage 0: clamp configuration, flags, position
   logic [CNT_W-1:0]  s_c;
   logic [LEN_W-1:0]  len_c;
   logic              err_in0, zero_in0, single_in0;
   logic [DEN_W-1:0]  d_in0;
   logic [P_W-1:0]    p_in0;
   logic [CNT_W-1:0]  smax_in0;

   logic              valid0_ff, err0_ff, zero0_ff, single0_ff;
   logic [DEN_W-1:0]  d0_ff;
   logic [P_W-1:0]    p0_ff;
   logic [CNT_W-1:0]  smax0_ff;

   always_comb begin
      s_c   = (stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count;
      len_c = (table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : table_length;
      err_in0    = (len_c == '0) || ({1'b0, in_index} >= len_c);
      zero_in0   = (s_c == '0);
      single_in0 = (s_c == CNT_W'(1)) || (len_c == LEN_W'(1));
      d_in0      = DEN_W'(len_c - LEN_W'(1));
      p_in0      = P_W'(in_index) * P_W'(CNT_W'(s_c - CNT_W'(1)));
      smax_in0   = CNT_W'(s_c - CNT_W'(2));
   end

   // stage 1: segment by comparing against multiples of the span
   logic [MUL_W-1:0]  mult [NSEG];
   logic [SEG_W-1:0]  seg_in1;
   logic [P_W-1:0]    n_full;
   logic [DEN_W-1:0]  n_in1, d_in1;

   logic              valid1_ff, err1_ff, zero1_ff;
   logic [SEG_W-1:0]  seg1_ff;
   logic [DEN_W-1:0]  n1_ff, d1_ff;

   always_comb begin
      for (int k = 0; k < NSEG; k++) begin
         mult[k] = MUL_W'(d0_ff) * MUL_W'(k);
      end
      seg_in1 = '0;
      for (int k = 1; k < NSEG; k++) begin
         if ((CNT_W'(k) <= smax0_ff) && (p0_ff >= P_W'(mult[k]))) begin
            seg_in1 = seg_in1 + SEG_W'(1);
         end
      end
      n_full = p0_ff - P_W'(mult[seg_in1]);
      n_in1  = n_full[DEN_W-1:0];
      d_in1  = d0_ff;
      // a single color: span of one, no blend, so the divider just rounds the stop
      if (single0_ff) begin
         seg_in1 = '0;
         n_in1   = '0;
         d_in1   = DEN_W'(1);
      end
   end

   // stage 2: pick the stop pair and form the two products per channel
   logic [2*STOP_W-1:0]       pairs [NSEG];
   logic [2*STOP_W-1:0]       pair_sel;
   logic signed [CHAN_W-1:0]  a_s [NCHAN];
   logic signed [CHAN_W-1:0]  b_s [NCHAN];
   logic signed [CHAN_W:0]    diff_s [NCHAN];
   logic signed [PA_W-1:0]    prod_a_in [NCHAN];
   logic signed [PB_W-1:0]    prod_b_in [NCHAN];

   logic                      valid2_ff, err2_ff, zero2_ff;
   logic [DEN_W-1:0]          d2_ff;
   logic signed [PA_W-1:0]    prod_a_ff [NCHAN];
   logic signed [PB_W-1:0]    prod_b_ff [NCHAN];

   always_comb begin
      for (int k = 0; k < NSEG; k++) begin
         pairs[k] = {stops[k], stops[k+1]};
      end
      pair_sel = pairs[seg1_ff];
      for (int c = 0; c < NCHAN; c++) begin
         a_s[c]       = chan_of(pair_sel[2*STOP_W-1 -: STOP_W], c);
         b_s[c]       = chan_of(pair_sel[STOP_W-1:0], c);
         diff_s[c]    = $signed({b_s[c][CHAN_W-1], b_s[c]}) - $signed({a_s[c][CHAN_W-1], a_s[c]});
         prod_a_in[c] = a_s[c] * $signed({1'b0, d1_ff});
         prod_b_in[c] = diff_s[c] * $signed({1'b0, n1_ff});
      end
   end

   // stage 3: t = a*d + (b-a)*n, numerator 2t+d for round half up
   logic signed [T_W-1:0] t_s [NCHAN];
   div_stage_type         item_in3;
   logic                  valid3_ff;
   div_stage_type         item3_ff;

   always_comb begin
      item_in3      = '0;
      item_in3.err  = err2_ff;
      item_in3.zero = zero2_ff;
      item_in3.den  = {d2_ff, 1'b0};
      for (int c = 0; c < NCHAN; c++) begin
         t_s[c] = T_W'(prod_a_ff[c]) + T_W'(prod_b_ff[c]);
         item_in3.rem[c] = (t_s[c] > 0) ? (NUM_W'(t_s[c]) << 1) + NUM_W'(d2_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (pipe_en) begin
         valid0_ff <= in_valid;
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         err0_ff    <= err_in0;
         zero0_ff   <= zero_in0;
         single0_ff <= single_in0;
         d0_ff      <= d_in0;
         p0_ff      <= p_in0;
         smax0_ff   <= smax_in0;

         err1_ff    <= err0_ff;
         zero1_ff   <= zero0_ff;
         seg1_ff    <= seg_in1;
         n1_ff      <= n_in1;
         d1_ff      <= d_in1;

         err2_ff    <= err1_ff;
         zero2_ff   <= zero1_ff;
         d2_ff      <= d1_ff;
         for (int c = 0; c < NCHAN; c++) begin
            prod_a_ff[c] <= prod_a_in[c];
            prod_b_ff[c] <= prod_b_in[c];
         end

         item3_ff   <= item_in3;
      end
   end

   assign out_valid = valid3_ff;
   assign out_item  = item3_ff;

endmodule

FILE: src/msgc_div.sv
// restoring divider pipeline, one quotient bit per stage for all three channels
// depends on msgc_pkg; fed by msgc_front, drains into msgc_out
module msgc_div
   import msgc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pipe_en,
   input  logic           in_valid,
   input  div_stage_type  in_item,
   output logic           out_valid,
   output div_stage_type  out_item
);

   logic [QUO_W-1:0] vld_ff;
   div_stage_type    st_ff  [QUO_W];
   div_stage_type    st_in  [QUO_W];
   div_stage_type    src;
   logic [NUM_W-1:0] shifted;

   // stage j settles quotient bit QUO_W-1-j
   always_comb begin
      for (int j = 0; j < QUO_W; j++) begin
         src     = (j == 0) ? in_item : st_ff[j-1];
         shifted = NUM_W'(src.den) << (QUO_W - 1 - j);
         st_in[j] = src;
         for (int c = 0; c < NCHAN; c++) begin
            if (src.rem[c] >= shifted) begin
               st_in[j].rem[c]               = src.rem[c] - shifted;
               st_in[j].quo[c][QUO_W-1-j]    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < QUO_W; j++) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_item  = st_ff[QUO_W-1];

endmodule

FILE: src/msgc_out.sv
// clamp to 0..1.0, output register and skid stage for the response channel
// depends on msgc_pkg; drives the pipeline enable for msgc_front and msgc_div
module msgc_out
   import msgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  div_stage_type         in_item,
   output logic                  pipe_en,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic [OUT_W-1:0]      ch [NCHAN];
   logic [RSP_DATA_W-1:0] data_in;

   logic                  out_valid_ff, out_err_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  skid_valid_ff, skid_err_ff;
   logic [RSP_DATA_W-1:0] skid_data_ff;

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         ch[c] = (in_item.quo[c] > QUO_W'(ONE_VALUE)) ? OUT_W'(ONE_VALUE) : in_item.quo[c];
         if (in_item.err || in_item.zero) begin
            ch[c] = '0;
         end
      end
      data_in = {(RSP_DATA_W - NCHAN*OUT_W)'(0), ch[2], ch[1], ch[0]};
   end

   // pipeline moves only while the skid slot is free
   assign pipe_en = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            out_err_ff  <= skid_err_ff;
         end else begin
            out_data_ff <= data_in;
            out_err_ff  <= in_item.err;
         end
      end else if (!skid_valid_ff) begin
         skid_data_ff <= data_in;
         skid_err_ff  <= in_item.err;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_err_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a request while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid request lost or changed during a stall");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("index error with nonzero color");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[OUT_W-1:0] <= OUT_W'(ONE_VALUE))
                   && (rsp_tdata[2*OUT_W-1:OUT_W] <= OUT_W'(ONE_VALUE))
                   && (rsp_tdata[3*OUT_W-1:2*OUT_W] <= OUT_W'(ONE_VALUE))))
      else $error("color channel above 1.0");

endmodule

FILE: src/multi_stop_gradient_color.sv
// Multi-stop linear color gradient lookup.
// Each request carries a table index; the response carries the red, green and
// blue values of that entry of a table interpolated between up to six color
// stops, each channel clamped to 0..16384 (16384 = 1.0).
// Configuration: csr_we writes csr_wdata into register csr_index (0 stop count,
// 1 table length, 2..7 stops 0..5, red in bits 47:32); write only while idle.
// A request accepted at one clock edge passes 20 registers (4 front stages,
// 15 divider stages, output register) before its response shows on rsp_*;
// the first of them loads at the accepting edge.
// Throughput: one request per cycle while not stalled, set by the fully pipelined
// 15-stage restoring divider that forms the rounded blend of all three channels.
// Reset clears all valid bits and sets stop count 0, table length 256 and all
// stops to 0; requests may follow the first cycle after reset.
// When rsp_tready is low the output register holds its response, one more
// response drops into a skid register, and req_tready then falls so the
// whole pipeline freezes without losing or repeating a request.
// Depends on msgc_pkg, msgc_front, msgc_div and msgc_out.
module multi_stop_gradient_color
   import msgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = entry_index[11:0], zero padded
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response: tdata = red[14:0], green[29:15], blue[44:30], zero padded
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // response tuser = index_error
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [STOP_W-1:0]     csr_wdata
);

   logic [CNT_W-1:0] stop_count_ff;
   logic [LEN_W-1:0] table_length_ff;
   stop_type         stops_ff [MAX_STOPS];

   logic             pipe_en;
   logic             front_valid, div_valid;
   div_stage_type    front_item, div_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff   <= '0;
         table_length_ff <= LEN_W'(256);
         for (int k = 0; k < MAX_STOPS; k++) begin
            stops_ff[k] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_STOP_COUNT: begin
               stop_count_ff <= csr_wdata[CNT_W-1:0];
            end
            CSR_TABLE_LENGTH: begin
               table_length_ff <= csr_wdata[LEN_W-1:0];
            end
            CSR_STOP_0, CSR_STOP_1, CSR_STOP_2, CSR_STOP_3, CSR_STOP_4, CSR_STOP_5: begin
               stops_ff[STOP_IDX_W'(csr_index - CSR_STOP_0)] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_tready = pipe_en;

   msgc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .pipe_en      (pipe_en),
      .in_valid     (req_tvalid),
      .in_index     (req_tdata[IDX_W-1:0]),
      .stop_count   (stop_count_ff),
      .table_length (table_length_ff),
      .stops        (stops_ff),
      .out_valid    (front_valid),
      .out_item     (front_item)
   );

   msgc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   msgc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_item    (div_item),
      .pipe_en    (pipe_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
